FILE: src/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// shared constants and codes for the water ripple frame step unit
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DIM_W      = 9;
    localparam int PIX_W      = 8;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 16;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PIX_W-1:0]  pix_t;

    typedef enum logic [1:0] {
        MODE_RAIN = 2'd0,
        MODE_STEP = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        pix_t  wdata;
        addr_t raddr;
    } ram_ctl_t;

endpackage

FILE: src/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram
// one height map: single write port, one registered read port
// ----------------------------------------------------------------------------
module wrs_ram (
    input  logic            clk,
    input  wrs_pkg::ram_ctl_t ctl,
    output wrs_pkg::pix_t   rdata
);
    import wrs_pkg::*;

    pix_t mem [0:(1 << ADDR_W) - 1];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end

endmodule

FILE: src/water_ripple_frame_step_unit.sv
// ----------------------------------------------------------------------------
// water_ripple_frame_step_unit
// two-map ripple engine: rain, frame step, pixel read and no-op over one stream
// ----------------------------------------------------------------------------
// channel   direction  words
// s_axis    in         mode, col, row, power
// m_axis    out        pixel, finished
// cfg       in         frame_width (index 0), frame_height (index 1)
//
// rain and no-op words set the result register directly; a read goes through the
// registered map read port. a step scans rows 1 to height-2, each column by
// column, with a 3x3 window: per column a shift, then three source reads on one
// port. after reset both maps are cleared; no word is taken then. a new word is
// taken in the idle state once the result register is empty or being drained.
// ----------------------------------------------------------------------------
module water_ripple_frame_step_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mode[1:0] col[9:2] row[17:10] power[25:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel[7:0] finished[8]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import wrs_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_STEP} state_t;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic              sel_reg, sel_next;
    logic              done_reg, done_next;
    logic              quiet_reg, quiet_next;
    addr_t             clr_reg, clr_next;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [ROW_W-1:0]  r_reg, r_next;
    logic [1:0]        ph_reg, ph_next;
    logic              inside_reg, inside_next;
    logic              ov_reg, ov_next;
    pix_t              opix_reg, opix_next;
    logic              ofin_reg, ofin_next;
    pix_t              wl_reg [3];
    pix_t              wm_reg [3];
    pix_t              wr_reg [3];

    ram_ctl_t          ctl_a, ctl_b;
    pix_t              q_a, q_b, cur_q, oth_q;

    mode_t             in_mode;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    pix_t              in_power;
    logic [DIM_W-1:0]  w_use, h_use;
    logic              in_inside, accept;

    logic              cur_we, oth_we, clr_we;
    addr_t             cur_waddr, cur_raddr, oth_addr;
    pix_t              cur_wdata, oth_wdata;
    logic [ROW_W-1:0]  src_row;
    logic [10:0]       sum;
    logic [8:0]        level, diff;
    logic              last_col, last_row, compute;

    wrs_ram u_map_a (.clk(clk), .ctl(ctl_a), .rdata(q_a));
    wrs_ram u_map_b (.clk(clk), .ctl(ctl_b), .rdata(q_b));

    assign in_mode  = mode_t'(s_tdata[1:0]);
    assign in_col   = s_tdata[9:2];
    assign in_row   = s_tdata[17:10];
    assign in_power = s_tdata[25:18];

    assign w_use = (width_reg < 9'd3) ? 9'd3 :
                   (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_use = (height_reg < 9'd3) ? 9'd3 :
                   (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign in_inside = ({1'b0, in_col} < w_use) && ({1'b0, in_row} < h_use);

    assign s_tready = (state_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign cur_q = sel_reg ? q_b : q_a;
    assign oth_q = sel_reg ? q_a : q_b;

    // window: left/mid columns held, right column arriving, last tap live
    assign sum = 11'(wl_reg[0]) + 11'(wm_reg[0]) + 11'(wr_reg[0]) + 11'(wl_reg[1])
               + 11'(wr_reg[1]) + 11'(wl_reg[2]) + 11'(wm_reg[2]) + 11'(cur_q);
    assign level = sum[10:2];
    assign diff  = level - 9'(oth_q);

    assign src_row  = r_reg + ROW_W'(ph_reg) - ROW_W'(1);
    assign oth_addr = {r_reg, x_reg - COL_W'(1)};
    assign last_col = ({1'b0, x_reg} == w_use - 9'd1);
    assign last_row = ({1'b0, r_reg} == h_use - 9'd2);
    assign compute  = (state_reg == ST_STEP) && (ph_reg == 2'd3) && (x_reg >= COL_W'(2));

    assign clr_we    = (state_reg == ST_CLEAR);
    assign cur_we    = clr_we || (accept && in_mode == MODE_RAIN && in_inside);
    assign cur_waddr = clr_we ? clr_reg : {in_row, in_col};
    assign cur_wdata = clr_we ? '0 : in_power;
    assign cur_raddr = (state_reg == ST_STEP) ? {src_row, x_reg} : {in_row, in_col};
    assign oth_we    = clr_we || compute;
    assign oth_wdata = clr_we ? '0 :
                       (level <= 9'(oth_q)) ? '0 :
                       (diff > 9'd255) ? 8'hFF : diff[7:0];

    always_comb
    begin
        ctl_a = '0;
        ctl_b = '0;
        if (!sel_reg)
        begin
            ctl_a = '{we: cur_we, waddr: cur_waddr, wdata: cur_wdata, raddr: cur_raddr};
            ctl_b = '{we: oth_we, waddr: clr_we ? clr_reg : oth_addr, wdata: oth_wdata,
                      raddr: oth_addr};
        end
        else
        begin
            ctl_b = '{we: cur_we, waddr: cur_waddr, wdata: cur_wdata, raddr: cur_raddr};
            ctl_a = '{we: oth_we, waddr: clr_we ? clr_reg : oth_addr, wdata: oth_wdata,
                      raddr: oth_addr};
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        done_next   = done_reg;
        quiet_next  = quiet_reg;
        clr_next    = clr_reg;
        x_next      = x_reg;
        r_next      = r_reg;
        ph_next     = ph_reg;
        inside_next = inside_reg;
        ov_next     = ov_reg && !m_tready;
        opix_next   = opix_reg;
        ofin_next   = ofin_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_STEP:
                        begin
                            state_next = ST_STEP;
                            quiet_next = 1'b1;
                            x_next     = '0;
                            r_next     = ROW_W'(1);
                            ph_next    = 2'd0;
                        end
                        MODE_READ:
                        begin
                            state_next  = ST_READ;
                            inside_next = in_inside;
                        end
                        default:
                        begin
                            if (in_mode == MODE_RAIN && in_inside)
                            begin
                                done_next = 1'b0;
                            end
                            ov_next   = 1'b1;
                            opix_next = '0;
                            ofin_next = (in_mode == MODE_RAIN && in_inside) ? 1'b0 : done_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                ov_next    = 1'b1;
                opix_next  = inside_reg ? cur_q : '0;
                ofin_next  = done_reg;
            end
            ST_STEP:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    if (compute && sum != '0)
                    begin
                        quiet_next = 1'b0;
                    end
                    if (last_col)
                    begin
                        x_next = '0;
                        if (last_row)
                        begin
                            state_next = ST_IDLE;
                            sel_next   = !sel_reg;
                            done_next  = quiet_next;
                            ov_next    = 1'b1;
                            opix_next  = '0;
                            ofin_next  = quiet_next;
                        end
                        else
                        begin
                            r_next = r_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        x_next = x_reg + COL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            sel_reg    <= 1'b0;
            done_reg   <= 1'b1;
            quiet_reg  <= 1'b1;
            clr_reg    <= '0;
            x_reg      <= '0;
            r_reg      <= '0;
            ph_reg     <= '0;
            inside_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            done_reg   <= done_next;
            quiet_reg  <= quiet_next;
            clr_reg    <= clr_next;
            x_reg      <= x_next;
            r_reg      <= r_next;
            ph_reg     <= ph_next;
            inside_reg <= inside_next;
            ov_reg     <= ov_next;
            if (cfg_we && cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // payload: result word and 3x3 window
    always_ff @(posedge clk)
    begin
        opix_reg <= opix_next;
        ofin_reg <= ofin_next;
        if (state_reg == ST_STEP)
        begin
            unique case (ph_reg)
                2'd0:
                begin
                    wl_reg <= wm_reg;
                    wm_reg <= wr_reg;
                end
                2'd1: wr_reg[0] <= cur_q;
                2'd2: wr_reg[1] <= cur_q;
                2'd3: wr_reg[2] <= cur_q;
                default: ;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, ofin_reg, opix_reg};

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("word taken during map clear");

    a_target_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        compute |-> (x_reg >= COL_W'(2)) && !cur_we)
        else $error("target write outside step window");

    a_swap_at_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != $past(sel_reg)) |-> ($past(state_reg) == ST_STEP) && m_tvalid)
        else $error("map swap without finished step");

    a_rain_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_RAIN && in_inside) |=> !done_reg && m_tvalid)
        else $error("rain did not clear finished flag");

endmodule
